/* hw/rtl/glu_pkg.sv */
// ----------------------------------------------------------------------------
// glu_pkg: shared types and constants for the gcd/lcm unit
// Field widths, controller state encoding and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;  // default active operand bits
  localparam int FIELD_WIDTH       = 32;  // port width of operands and gcd
  localparam int LCM_WIDTH         = 64;  // port width of the lcm

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture operands, start the gcd loop
    logic gcd_step;   // one binary-gcd reduction
    logic gcd_latch;  // latch gcd, set up divider and multiplier
    logic div_step;   // one restoring-divide bit
    logic mul_step;   // one shift-add multiply bit
  } cmd_t;

  typedef struct packed {
    logic gcd_zero;   // one gcd working value has reached zero
    logic op_zero;    // either captured operand is zero
    logic cnt_last;   // bit counter on its last step
  } sts_t;

endpackage

/* hw/rtl/glu_ctrl.sv */
// ----------------------------------------------------------------------------
// glu_ctrl: sequencing state machine
// Walks one operand pair through gcd reduction and, unless an operand is zero,
// a/gcd division and final multiply; raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module glu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  glu_pkg::sts_t sts,
  output glu_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  glu_pkg::state_t state;
  glu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      glu_pkg::ST_IDLE: begin
        if (start) state_next = glu_pkg::ST_GCD;
      end
      glu_pkg::ST_GCD: begin
        if (sts.gcd_zero) begin
          // a zero operand gives lcm 0: skip divide and multiply
          state_next = sts.op_zero ? glu_pkg::ST_DONE : glu_pkg::ST_DIV;
        end
      end
      glu_pkg::ST_DIV: begin
        if (sts.cnt_last) state_next = glu_pkg::ST_MUL;
      end
      glu_pkg::ST_MUL: begin
        if (sts.cnt_last) state_next = glu_pkg::ST_DONE;
      end
      glu_pkg::ST_DONE: begin
        state_next = glu_pkg::ST_IDLE;
      end
      default: begin
        state_next = glu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      glu_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      glu_pkg::ST_GCD: begin
        cmd.gcd_latch = sts.gcd_zero;
        cmd.gcd_step  = !sts.gcd_zero;
      end
      glu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      glu_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
      end
      glu_pkg::ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

/* hw/rtl/glu_dp.sv */
// ----------------------------------------------------------------------------
// glu_dp: gcd/lcm datapath
// Binary gcd with one reduction per cycle, a bit-serial restoring divider
// for a/gcd and a shift-add multiplier for (a/gcd)*b.
// ----------------------------------------------------------------------------
module glu_dp #(
  parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  glu_pkg::cmd_t                     cmd,
  output glu_pkg::sts_t                     sts,
  input  logic [glu_pkg::FIELD_WIDTH-1:0]   operand_a,
  input  logic [glu_pkg::FIELD_WIDTH-1:0]   operand_b,
  output logic [glu_pkg::FIELD_WIDTH-1:0]   gcd_value,
  output logic [glu_pkg::LCM_WIDTH-1:0]     lcm_value
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam int KW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic [W-1:0]   a_s, b_s;
  logic [W-1:0]   x, y;
  logic [KW-1:0]  k;
  logic [W-1:0]   g;
  logic [W-1:0]   r;
  logic [W-1:0]   q;
  logic [2*W-1:0] mc;
  logic [2*W-1:0] acc;
  logic [CW-1:0]  cnt;

  logic [W:0]     rs;
  logic [W:0]     rdiff;
  logic [W-1:0]   xy_diff, yx_diff;
  logic           x_ge_y;

  assign rs      = {r, q[W-1]};
  assign rdiff   = rs - {1'b0, g};
  assign x_ge_y  = (x >= y);
  assign xy_diff = x - y;
  assign yx_diff = y - x;

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_s <= operand_a[W-1:0];
      b_s <= operand_b[W-1:0];
      x   <= operand_a[W-1:0];
      y   <= operand_b[W-1:0];
      k   <= '0;
    end
    if (cmd.gcd_step) begin
      if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + KW'(1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x_ge_y) begin
        // odd minus odd is even: fold the halving in
        x <= xy_diff >> 1;
      end else begin
        y <= yx_diff >> 1;
      end
    end
    if (cmd.gcd_latch) begin
      g   <= (x | y) << k;
      r   <= '0;
      q   <= a_s;
      mc  <= {{W{1'b0}}, b_s};
      acc <= '0;
    end
    if (cmd.div_step) begin
      if (!rdiff[W]) begin
        r <= rdiff[W-1:0];
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= rs[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
    end
    if (cmd.mul_step) begin
      if (q[0]) acc <= acc + mc;
      mc <= mc << 1;
      q  <= q >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.gcd_latch) begin
      cnt <= '0;
    end else if (cmd.div_step || cmd.mul_step) begin
      cnt <= (cnt == CNT_LAST) ? '0 : cnt + CW'(1);
    end
  end

  assign sts.gcd_zero = (x == '0) || (y == '0);
  assign sts.op_zero  = (a_s == '0) || (b_s == '0);
  assign sts.cnt_last = (cnt == CNT_LAST);

  always_comb begin
    gcd_value        = '0;
    gcd_value[W-1:0] = g;
    lcm_value          = '0;
    lcm_value[2*W-1:0] = acc;
  end

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_latch |=> (g != '0) || ((a_s == '0) && (b_s == '0)))
    else $error("gcd zero with a nonzero operand");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (r < g))
    else $error("divider remainder not below gcd");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_LAST)
    else $error("bit counter out of range");

endmodule

/* hw/rtl/gcd_lcm_unit.sv */
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// The binary-gcd loop makes one reduction per cycle. A pair with a zero
// operand then goes straight to done; any other pair first passes through
// the bit-serial a/gcd divide and the shift-add multiply by b.
// One pair at a time: busy stays high through the done strobe, and the next
// start is taken in the idle cycle after it.
// The done beat cannot be held off. Synchronous reset returns the controller
// to idle and clears the bit counter; no other state is reset.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [glu_pkg::FIELD_WIDTH-1:0] operand_a,
  input  logic [glu_pkg::FIELD_WIDTH-1:0] operand_b,
  output logic                            done,
  output logic [glu_pkg::FIELD_WIDTH-1:0] gcd_value,
  output logic [glu_pkg::LCM_WIDTH-1:0]   lcm_value
);

  glu_pkg::cmd_t cmd;
  glu_pkg::sts_t sts;

  glu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  glu_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .gcd_value (gcd_value),
    .lcm_value (lcm_value)
  );

endmodule

/* tb/sv/gcd_lcm_unit_test.sv */
// ----------------------------------------------------------------------------
// gcd_lcm_unit_test: self-checking bench for the gcd/lcm unit
// Drives operand pairs through the start/busy handshake and computes each
// gcd and lcm with Euclid's algorithm. Every done beat is checked against the
// oldest outstanding pair. Directed corner pairs come first, then random
// streams under several sender idle rates, with one full drain along the way.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_test;

  localparam int ACTIVE_BITS = glu_pkg::OPERAND_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 4 * ACTIVE_BITS + 16;  // beyond worst latency
  localparam int MAX_REPORTS = 10;

  typedef logic [glu_pkg::FIELD_WIDTH-1:0] operand_t;
  typedef logic [glu_pkg::LCM_WIDTH-1:0]   lcm_t;

  typedef struct {
    operand_t a;
    operand_t b;
    operand_t gcd;
    lcm_t     lcm;
  } gcd_lcm_pair_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  operand_t operand_a;
  operand_t operand_b;
  logic     done;
  operand_t gcd_value;
  lcm_t     lcm_value;

  gcd_lcm_pair_t pending_results[$];
  int            mismatch_count = 0;
  int            idle_pct = 0;

  gcd_lcm_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done     (done),
    .gcd_value(gcd_value),
    .lcm_value(lcm_value)
  );

  always #2 clk = ~clk;

  // Euclid on the masked operands; lcm is (a / gcd) * b at full 64 bits
  function automatic gcd_lcm_pair_t predict_gcd_lcm(operand_t a, operand_t b);
    gcd_lcm_pair_t r;
    logic [63:0]   mask;
    logic [63:0]   x;
    logic [63:0]   y;
    logic [63:0]   t;
    mask = (64'd1 << ACTIVE_BITS) - 64'd1;
    x = {32'd0, a} & mask;
    y = {32'd0, b} & mask;
    r.a = a;
    r.b = b;
    r.lcm = '0;
    if (x != 0 && y != 0) begin
      t = x;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      r.lcm = (({32'd0, a} & mask) / x) * ({32'd0, b} & mask);
    end else begin
      x = x | y;
    end
    r.gcd = x[glu_pkg::FIELD_WIDTH-1:0];
    return r;
  endfunction

  // one command beat: optional idle gap, then hold start until accepted
  task automatic send_pair(input operand_t a, input operand_t b);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start     <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_gcd_lcm(a, b));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // done beats are checked on the pre-edge values
  always @(posedge clk) begin
    gcd_lcm_pair_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: gcd=%0d lcm=%0d", gcd_value, lcm_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (gcd_value !== exp_r.gcd || lcm_value !== exp_r.lcm) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch a=%0d b=%0d: gcd exp %0d got %0d, lcm exp %0d got %0d",
                     exp_r.a, exp_r.b, exp_r.gcd, gcd_value, exp_r.lcm, lcm_value);
        end
      end
    end
  end

  function automatic operand_t rand_operand();
    operand_t v;
    v = $urandom();
    case ($urandom_range(5))
      0: v = v >> $urandom_range(31);
      1: v = operand_t'(1) << $urandom_range(31);
      2: v = v | 32'h8000_0000;
      3: v = v >> $urandom_range(16, 28);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random_pair();
    operand_t a;
    operand_t b;
    operand_t g;
    int       k;
    a = rand_operand();
    b = rand_operand();
    case ($urandom_range(9))
      4, 5: begin
        // shared factor with small cofactors
        g = $urandom() >> $urandom_range(8, 31);
        a = g * ($urandom() >> $urandom_range(16, 31));
        b = g * ($urandom() >> $urandom_range(16, 31));
      end
      6: begin
        // shared power of two
        k = $urandom_range(31);
        a = a << k;
        b = b << k;
      end
      7: begin
        b = ($urandom_range(1)) ? a : a * $urandom_range(1, 7);
      end
      8: begin
        if ($urandom_range(1)) a = '0; else b = '0;
        if ($urandom_range(7) == 0) begin
          a = '0;
          b = '0;
        end
      end
      9: begin
        a = $urandom();
        b = $urandom();
      end
      default: ;
    endcase
    send_pair(a, b);
  endtask

  task automatic test_corner_pairs();
    idle_pct = 0;
    send_pair(32'd0, 32'd0);
    send_pair(32'd0, 32'd12345);
    send_pair(32'hFFFF_FFFF, 32'd0);
    send_pair(32'd1, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd1);
    send_pair(32'd1, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_pair(32'd4294967291, 32'd4294967279);  // two primes: lcm near 2^64
    send_pair(32'h8000_0000, 32'h4000_0000);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'd12, 32'd18);
    send_pair(32'd1071, 32'd462);
    send_pair(32'd7, 32'd49000);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'd2, 32'hFFFF_FFFF);
    send_pair(32'hFFFE_0000, 32'h0001_FFFE);
    send_pair(32'd3, 32'd0);
  endtask

  task automatic test_random_stream(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_random_pair();
  endtask

  // sender holds off until every outstanding beat has come back
  task automatic test_drain_then_resume();
    idle_pct = 0;
    repeat (20) send_random_pair();
    start <= 1'b0;
    wait_drained();
    @(posedge clk);
    repeat (30) send_random_pair();
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    operand_a = '0;
    operand_b = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_pairs();
    test_random_stream(600, 0);
    test_random_stream(600, 74);
    test_drain_then_resume();
    test_random_stream(600, 11);

    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
